// ===== rtl/oskm_pkg.sv =====
// ----------------------------------------------------------------------------
// oskm_pkg
// Shared types and constants for the order-statistic multiset block.
// ----------------------------------------------------------------------------
package oskm_pkg;

   localparam int KEY_W    = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // number of keys the chain holds; occupancy and rank are sized from it
   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

// ===== rtl/oskm_req_if.sv =====
// ----------------------------------------------------------------------------
// oskm_req_if
// Request channel: operation, key and rank with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface oskm_req_if
   import oskm_pkg::*;
();

   logic                     valid;
   logic                     ready;
   logic        [OP_W-1:0]   op;
   logic signed [KEY_W-1:0]  key_value;
   logic        [COUNT_W-1:0] rank;

   modport source (output valid, output op, output key_value, output rank, input ready);
   modport sink   (input valid, input op, input key_value, input rank, output ready);

endinterface

// ===== rtl/oskm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// oskm_rsp_if
// Response channel: found key, status and occupancy with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface oskm_rsp_if
   import oskm_pkg::*;
();

   logic                      valid;
   logic                      ready;
   logic signed [KEY_W-1:0]   found_value;
   logic        [STATUS_W-1:0] status;
   logic        [COUNT_W-1:0] occupancy;

   modport source (output valid, output found_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input found_value, input status, input occupancy,
                   output ready);

endinterface

// ===== rtl/order_statistic_set_kth_max_top.sv =====
// ----------------------------------------------------------------------------
// order_statistic_set_kth_max_top
// Bounded multiset of signed keys kept in an ascending register chain, with
// insert, remove-all-copies and k-th largest query.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the response is not stalled and
// returns one response per request. A request accepted into the input register
// is processed from there into the response register; a stalled response holds
// the following request in the input register. Unless the response stalls,
// throughput is one request per cycle: every entry of the sorted chain
// compares against the key and moves in parallel within a single pass, so each
// request sees the state left by the one before it. Insert into a full set is
// dropped with status full; remove of an absent key is a no-op; a query with
// rank zero or above the occupancy returns status range and a zero key. Op code
// 3 is ignored. Entries above the occupancy hold stale data and are never shown.
module order_statistic_set_kth_max_top
   import oskm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   oskm_req_if.sink   req_chan,
   oskm_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic        [OP_W-1:0]  in_op_ff;
   logic signed [KEY_W-1:0] in_key_ff;
   logic        [CW-1:0]    in_rank_ff;

   // sorted chain
   logic signed [KEY_W-1:0] keys_ff [CAPACITY];
   logic signed [KEY_W-1:0] keys_in [CAPACITY];
   logic        [CW-1:0]    count_ff, count_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0]   rsp_found_ff, rsp_found_in;
   logic        [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic        [CW-1:0]      rsp_occ_ff;

   logic fire;
   logic take;

   logic        [CAPACITY:0]  lt_x, le_x;
   logic        [CW-1:0]      lo_pos, hi_pos, del_cnt;
   logic signed [KEY_W-1:0]   ins_keys [CAPACITY];
   logic signed [KEY_W-1:0]   rm_keys  [CAPACITY];
   logic signed [KEY_W-1:0]   stg      [CW+1][CAPACITY];
   logic                      is_full, rank_ok;
   logic        [IW-1:0]      q_idx;

   assign fire = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || fire;

   // Compare every held entry against the key.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_x[i] = (CW'(i) < count_ff) && (keys_ff[i] <  in_key_ff);
         le_x[i] = (CW'(i) < count_ff) && (keys_ff[i] <= in_key_ff);
      end
      lt_x[CAPACITY] = 1'b0;
      le_x[CAPACITY] = 1'b0;
   end

   // Locate the one-hot edge of each thermometer code.
   always_comb begin
      lo_pos = '0;
      hi_pos = '0;
      for (int i = 0; i <= CAPACITY; i++) begin
         if (((i == 0) || lt_x[(i == 0) ? 0 : i-1]) && !lt_x[i]) begin
            lo_pos = lo_pos | CW'(i);
         end
         if (((i == 0) || le_x[(i == 0) ? 0 : i-1]) && !le_x[i]) begin
            hi_pos = hi_pos | CW'(i);
         end
      end
      del_cnt = hi_pos - lo_pos;
   end

   // Insert: keep smaller keys, drop the new key at the edge, shift the rest up.
   always_comb begin
      ins_keys[0] = lt_x[0] ? keys_ff[0] : in_key_ff;
      for (int i = 1; i < CAPACITY; i++) begin
         if (lt_x[i]) begin
            ins_keys[i] = keys_ff[i];
         end else if (CW'(i) == lo_pos) begin
            ins_keys[i] = in_key_ff;
         end else begin
            ins_keys[i] = keys_ff[i-1];
         end
      end
   end

   // Remove: shift everything down by the number of matches, keep the part below.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         stg[0][i] = keys_ff[i];
      end
      for (int b = 0; b < CW; b++) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (del_cnt[b]) begin
               stg[b+1][i] = (i + (1 << b) < CAPACITY) ? stg[b][(i + (1 << b)) % CAPACITY]
                                                       : '0;
            end else begin
               stg[b+1][i] = stg[b][i];
            end
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         rm_keys[i] = (CW'(i) < lo_pos) ? keys_ff[i] : stg[CW][i];
      end
   end

   assign is_full = (count_ff == CW'(CAPACITY));
   assign rank_ok = (in_rank_ff != '0) && (in_rank_ff <= count_ff);
   assign q_idx   = IW'(count_ff - in_rank_ff);

   always_comb begin
      keys_in       = keys_ff;
      count_in      = count_ff;
      rsp_found_in  = '0;
      rsp_status_in = ST_OK;
      case (in_op_ff)
         OP_INSERT: begin
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               keys_in  = ins_keys;
               count_in = count_ff + CW'(1);
            end
         end
         OP_REMOVE: begin
            keys_in  = rm_keys;
            count_in = count_ff - del_cnt;
         end
         OP_QUERY: begin
            if (rank_ok) begin
               rsp_found_in = keys_ff[q_idx];
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_chan.op;
         in_key_ff  <= req_chan.key_value;
         in_rank_ff <= req_chan.rank;
      end
      if (fire) begin
         keys_ff       <= keys_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= count_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found_value = rsp_found_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.occupancy   = rsp_occ_ff;

endmodule

// ===== rtl/oskm_checker.sv =====
// ----------------------------------------------------------------------------
// oskm_checker
// Port-level checks on the order-statistic multiset block, bound to the top.
// ----------------------------------------------------------------------------
module oskm_checker
   import oskm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [KEY_W-1:0]   rsp_found_value,
   input logic        [STATUS_W-1:0] rsp_status,
   input logic        [COUNT_W-1:0] rsp_occupancy
);

   localparam int CW = COUNT_W;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == CW'(CAPACITY))
      else $error("full status with room left");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_RANGE)
      |-> rsp_found_value == '0)
      else $error("nonzero key on an error response");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind order_statistic_set_kth_max_top oskm_checker u_oskm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found_value (rsp_chan.found_value),
   .rsp_status      (rsp_chan.status),
   .rsp_occupancy   (rsp_chan.occupancy)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted multiset with k-th largest query. A
// short table of requests covers the empty set, the key extremes, duplicates,
// the rank limits and the unused op code. Random traffic then fills the set
// past capacity, drains it and queries it. Every response is compared with its
// table entry or a software copy of the sorted key chain. Both channels idle at
// random, and the response side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   import oskm_pkg::*;

   localparam int RANDOM_REQUESTS  = 1630;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES     = 8;
   localparam int MAX_REPORTS      = 10;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [KEY_W-1:0]    found_value;
      logic        [STATUS_W-1:0] status;
      logic        [COUNT_W-1:0]  occupancy;
   } set_reply_type;

   typedef struct packed {
      logic        [OP_W-1:0]    op;
      logic signed [KEY_W-1:0]   key_value;
      logic        [COUNT_W-1:0] rank;
      bit                        typed;
      set_reply_type             reply;
   } set_request_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   oskm_req_if req_chan ();
   oskm_rsp_if rsp_chan ();

   order_statistic_set_kth_max_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // software copy of the ascending key chain
   logic signed [KEY_W-1:0] held_keys [CAPACITY];
   int                      held_count;

   set_reply_type   pending_replies [$];
   set_request_type directed_rows [$];

   int  mismatch_count;
   bit  sender_idling;
   bit  sink_idling;
   bit  long_hold_pending;
   int  long_holds_done;
   int  n_insert, n_remove, n_query, n_unused, n_full, n_range, n_found, peak_count;

   logic signed [KEY_W-1:0] key_pool [8] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
      32'sh0000_0001, 32'sh7FFF_FFFE, 32'sh8000_0001, 32'sh5555_5555
   };

   function automatic set_reply_type apply_to_multiset(input logic [OP_W-1:0] op,
                                                       input logic signed [KEY_W-1:0] key,
                                                       input logic [COUNT_W-1:0] rank);
      set_reply_type reply;
      int            pos;
      int            kept;
      reply = '0;
      case (op)
         OP_INSERT: begin
            if (held_count >= CAPACITY) begin
               reply.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < held_count && held_keys[pos] < key) pos++;
               for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
               held_keys[pos] = key;
               held_count++;
            end
         end
         OP_REMOVE: begin
            kept = 0;
            for (int i = 0; i < held_count; i++) begin
               if (held_keys[i] != key) begin
                  held_keys[kept] = held_keys[i];
                  kept++;
               end
            end
            held_count = kept;
         end
         OP_QUERY: begin
            if (rank == 0 || rank > held_count) reply.status = ST_RANGE;
            else reply.found_value = held_keys[held_count - rank];
         end
         default: ;
      endcase
      reply.occupancy = COUNT_W'(held_count);
      return reply;
   endfunction

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return key_pool[$urandom_range(0, 7)];
         default: return $signed($urandom_range(0, 40)) - 20;
      endcase
   endfunction

   // drive one request, wait for its handshake, then record what it should return
   task automatic issue_request(input set_request_type request);
      int            gap;
      set_reply_type predicted;
      gap = sender_idling ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= request.op;
      req_chan.key_value <= request.key_value;
      req_chan.rank      <= request.rank;
      do @(posedge clock); while (!req_chan.ready);
      predicted = apply_to_multiset(request.op, request.key_value, request.rank);
      pending_replies.push_back(request.typed ? request.reply : predicted);
      case (request.op)
         OP_INSERT: n_insert++;
         OP_REMOVE: n_remove++;
         OP_QUERY:  n_query++;
         default:   n_unused++;
      endcase
      if (predicted.status == ST_FULL) n_full++;
      if (predicted.status == ST_RANGE) n_range++;
      if (request.op == OP_QUERY && predicted.status == ST_OK) n_found++;
      if (held_count > peak_count) peak_count = held_count;
   endtask

   task automatic add_row(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                          input logic [COUNT_W-1:0] rank, input bit typed,
                          input logic signed [KEY_W-1:0] found,
                          input logic [STATUS_W-1:0] status,
                          input logic [COUNT_W-1:0] occupancy);
      set_request_type row;
      row.op        = op;
      row.key_value = key;
      row.rank      = rank;
      row.typed     = typed;
      row.reply     = '{found_value: found, status: status, occupancy: occupancy};
      directed_rows.push_back(row);
   endtask

   // response sink with random stalls and an occasional long hold-off
   initial begin : response_sink
      int hold;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold_pending) begin
            hold = LONG_HOLD_CYCLES;
            long_hold_pending = 1'b0;
            long_holds_done++;
         end else begin
            hold = sink_idling ? $urandom_range(0, 8) : 0;
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin
      set_reply_type wanted;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_replies.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("mismatch: unexpected response found=%h status=%0d occ=%0d",
                        rsp_chan.found_value, rsp_chan.status, rsp_chan.occupancy);
            mismatch_count++;
         end else begin
            wanted = pending_replies.pop_front();
            if (rsp_chan.found_value !== wanted.found_value || rsp_chan.status !== wanted.status ||
                rsp_chan.occupancy !== wanted.occupancy) begin
               if (mismatch_count < MAX_REPORTS) begin
                  $display("mismatch: expected found=%h status=%0d occ=%0d,",
                           wanted.found_value, wanted.status, wanted.occupancy);
                  $display("          got      found=%h status=%0d occ=%0d",
                           rsp_chan.found_value, rsp_chan.status, rsp_chan.occupancy);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      set_request_type request;
      traffic_mix_type mix;
      int              sent;
      int              phase;
      int              phase_len;
      int              roll;

      req_chan.valid     <= 1'b0;
      req_chan.op        <= OP_INSERT;
      req_chan.key_value <= '0;
      req_chan.rank      <= '0;
      held_count    = 0;
      sender_idling = 1'b1;
      sink_idling   = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty set, extremes, duplicates, rank limits, unused op code
      add_row(OP_QUERY,  32'sh0,          7'd1,   1'b1, 32'sh0,          ST_RANGE, 7'd0);
      add_row(OP_QUERY,  32'sh0,          7'd0,   1'b1, 32'sh0,          ST_RANGE, 7'd0);
      add_row(OP_REMOVE, 32'sh5,          7'd0,   1'b1, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_UNUSED, 32'shFFFF_FFFF,  7'd127, 1'b1, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_INSERT, 32'sh7FFF_FFFF,  7'd0,   1'b1, 32'sh0,          ST_OK,    7'd1);
      add_row(OP_INSERT, 32'sh8000_0000,  7'd0,   1'b1, 32'sh0,          ST_OK,    7'd2);
      add_row(OP_INSERT, 32'sh0,          7'd0,   1'b1, 32'sh0,          ST_OK,    7'd3);
      add_row(OP_INSERT, 32'shFFFF_FFFF,  7'd0,   1'b1, 32'sh0,          ST_OK,    7'd4);
      add_row(OP_INSERT, 32'sh0,          7'd0,   1'b1, 32'sh0,          ST_OK,    7'd5);
      add_row(OP_QUERY,  32'sh0,          7'd1,   1'b1, 32'sh7FFF_FFFF,  ST_OK,    7'd5);
      add_row(OP_QUERY,  32'sh0,          7'd5,   1'b1, 32'sh8000_0000,  ST_OK,    7'd5);
      add_row(OP_QUERY,  32'sh0,          7'd6,   1'b1, 32'sh0,          ST_RANGE, 7'd5);
      add_row(OP_QUERY,  32'sh0,          7'd0,   1'b1, 32'sh0,          ST_RANGE, 7'd5);
      add_row(OP_QUERY,  32'shFFFF_FFFF,  7'd127, 1'b1, 32'sh0,          ST_RANGE, 7'd5);
      add_row(OP_QUERY,  32'sh0,          7'd3,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_REMOVE, 32'sh0,          7'd0,   1'b1, 32'sh0,          ST_OK,    7'd3);
      add_row(OP_QUERY,  32'sh0,          7'd2,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_REMOVE, 32'sh8000_0000,  7'd0,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_REMOVE, 32'sh7FFF_FFFF,  7'd0,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_QUERY,  32'sh0,          7'd1,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_INSERT, 32'sh5555_5555,  7'd0,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_INSERT, 32'shAAAA_AAAA,  7'd0,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_QUERY,  32'sh0,          7'd2,   1'b0, 32'sh0,          ST_OK,    7'd0);
      add_row(OP_UNUSED, 32'sh0,          7'd0,   1'b1, 32'sh0,          ST_OK,    7'd3);
      foreach (directed_rows[i]) issue_request(directed_rows[i]);

      // random phases; the first one fills the set past capacity
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (phase == 0) mix = MIX_FILL;
         else mix = traffic_mix_type'($urandom_range(0, 2));
         phase_len = (phase == 0) ? 120 : $urandom_range(40, 120);
         roll = $urandom_range(0, 3);
         sender_idling = (roll != 0) && $urandom_range(0, 1);
         sink_idling   = (roll != 0) && $urandom_range(0, 1);
         // back the block up: sender keeps offering while the sink holds off
         if (phase == 2 || phase == 11) begin
            sender_idling     = 1'b0;
            long_hold_pending = 1'b1;
         end
         for (int n = 0; n < phase_len && sent < RANDOM_REQUESTS; n++) begin
            roll = $urandom_range(0, 99);
            case (mix)
               MIX_FILL:  request.op = (roll < 70) ? OP_INSERT : (roll < 75) ? OP_REMOVE :
                                       (roll < 98) ? OP_QUERY : OP_UNUSED;
               MIX_DRAIN: request.op = (roll < 15) ? OP_INSERT : (roll < 50) ? OP_REMOVE :
                                       (roll < 98) ? OP_QUERY : OP_UNUSED;
               default:   request.op = (roll < 40) ? OP_INSERT : (roll < 60) ? OP_REMOVE :
                                       (roll < 97) ? OP_QUERY : OP_UNUSED;
            endcase
            request.key_value = pick_key();
            request.rank      = COUNT_W'($urandom_range(0, 127));
            if (request.op == OP_REMOVE && held_count > 0 && $urandom_range(0, 3) != 0)
               request.key_value = held_keys[$urandom_range(0, held_count - 1)];
            if (request.op == OP_QUERY && held_count > 0 && $urandom_range(0, 4) != 0)
               request.rank = COUNT_W'($urandom_range(1, held_count));
            request.typed = 1'b0;
            request.reply = '0;
            issue_request(request);
            sent++;
         end
         phase++;
      end
      req_chan.valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d inserts (%0d full), %0d removes, %0d queries (%0d hit, %0d out of range)",
               n_insert, n_full, n_remove, n_query, n_found, n_range);
      $display("run: %0d unused-op requests, peak occupancy %0d of %0d, %0d long sink hold-offs",
               n_unused, peak_count, CAPACITY, long_holds_done);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #1_600_000;
      $display("timeout with %0d responses outstanding", pending_replies.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/oskm_pkg.sv
rtl/oskm_req_if.sv
rtl/oskm_rsp_if.sv
rtl/order_statistic_set_kth_max_top.sv
rtl/oskm_checker.sv
tb/tb_top.sv
